@@ src/rbsi_pkg.sv @@
package rbsi_pkg;

	// Register indexes of the box corners
	localparam int unsigned REG_MIN_X = 0;
	localparam int unsigned REG_MIN_Y = 1;
	localparam int unsigned REG_MIN_Z = 2;
	localparam int unsigned REG_MAX_X = 3;
	localparam int unsigned REG_MAX_Y = 4;
	localparam int unsigned REG_MAX_Z = 5;
	localparam int unsigned NUM_REGS  = 6;
	localparam int unsigned NUM_AXES  = 3;

	// Status for one slab quotient
	typedef struct packed {
		logic neg;    // quotient sign
		logic sat;    // quotient already out of range
		logic par;    // direction zero
		logic pmiss;  // parallel and origin outside slab
	} rbsi_qflags_t;

endpackage

@@ src/rbsi_div.sv @@
// Pipelined fixed-point divider: (num << FB) / den, truncated toward zero,
// saturated to a CW-bit signed result. One quotient bit per stage.
module rbsi_div import rbsi_pkg::*; #(
	parameter int CW = 32,
	parameter int FB = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [CW:0]          num,
	input  logic [CW-1:0]        den,
	output logic [CW-1:0]        quo
);
	localparam int NW = CW + 1;          // magnitude of the numerator
	localparam int QB = NW + FB;         // quotient bits produced
	localparam int DW = CW + 1;          // remainder width
	localparam int SG = QB + 1;          // input register plus one per quotient bit

	logic [NW-1:0] n_s  [SG];
	logic [DW-1:0] r_s  [SG];
	logic [DW-1:0] d_s  [SG];
	logic [QB-1:0] q_s  [SG];
	logic          ng_s [SG];

	logic [NW-1:0] n_abs;
	logic [CW-1:0] d_abs;
	assign n_abs = num[CW] ? NW'(-num) : NW'(num);
	assign d_abs = den[CW-1] ? CW'(-den) : den;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0]  <= n_abs;
			r_s[0]  <= '0;
			d_s[0]  <= DW'(d_abs);
			q_s[0]  <= '0;
			ng_s[0] <= num[CW] ^ den[CW-1];
		end
	end

	for (genvar i = 0; i < QB; i++) begin : g_step
		logic [DW:0] sh;
		logic [DW:0] df;
		logic        bit_in;
		assign bit_in = (i < NW) ? n_s[i][NW-1-((i < NW) ? i : 0)] : 1'b0;
		assign sh = {r_s[i], bit_in};
		assign df = sh - {1'b0, d_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[i+1]  <= n_s[i];
				d_s[i+1]  <= d_s[i];
				ng_s[i+1] <= ng_s[i];
				r_s[i+1]  <= df[DW] ? sh[DW-1:0] : df[DW-1:0];
				q_s[i+1]  <= {q_s[i][QB-2:0], ~df[DW]};
			end
		end
	end

	localparam logic [QB-1:0] LIM_P = QB'((64'd1 << (CW-1)) - 64'd1);
	localparam logic [QB-1:0] LIM_N = QB'(64'd1 << (CW-1));

	logic [CW-1:0] res;
	always_comb begin
		if (ng_s[QB]) begin
			res = (q_s[QB] > LIM_N) ? LIM_N[CW-1:0] : CW'(-q_s[QB]);
		end else begin
			res = (q_s[QB] > LIM_P) ? LIM_P[CW-1:0] : q_s[QB][CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= res;
		end
	end

	logic unused_rst;
	assign unused_rst = arst_n;
endmodule

@@ src/ray_box_slab_intersect_top.sv @@
// Ray versus box slab test.
// A ray passes stage 1, the one-bit-per-stage quotient pipeline, stage 2
// and stage 3 on its way from input transfer to result.
// Throughput: one ray per cycle; the whole pipeline holds while the output
// is stalled.  Reset clears valid bits and box registers to zero.
module ray_box_slab_intersect_top import rbsi_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [4:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	input  logic [6*COORD_WIDTH-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// t_near, t_far
	output logic [2*COORD_WIDTH-1:0]    m_tdata,
	// hit
	output logic                        m_tuser
);
	localparam int CW  = COORD_WIDTH;
	localparam int DL  = CW + 1 + FRAC_BITS + 2;   // divider latency
	localparam int LAT = DL + 3;                   // s1, div, s2, s3
	localparam logic [CW-1:0] TMAX = CW'((64'd1 << (CW-1)) - 64'd1);
	localparam logic [CW-1:0] TMIN = CW'(64'd1 << (CW-1));

	logic [CW-1:0] box_q [NUM_REGS];
	logic [2:0] ridx;
	assign ridx = paddr[4:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) box_q[i] <= '0;
		end else if (psel && penable && pwrite && 32'(ridx) < NUM_REGS) begin
			box_q[ridx] <= CW'(pwdata);
		end
	end

	always_comb begin
		prdata = '0;
		if (32'(ridx) < NUM_REGS) prdata = 32'(box_q[ridx]);
	end

	// Output register without skid buffer: advance whole pipe when output slot is free
	logic en;
	logic [LAT-1:0] v_q;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[LAT-2:0], s_tvalid};
		end
	end
	assign m_tvalid = v_q[LAT-1];

	// Stage 1: differences and parallel checks
	logic [CW:0]   dmn_s1 [NUM_AXES];
	logic [CW:0]   dmx_s1 [NUM_AXES];
	logic [CW-1:0] dir_s1 [NUM_AXES];
	logic          par_s1 [NUM_AXES];
	logic          pm_s1  [NUM_AXES];

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_ax
		logic signed [CW-1:0] o, d, mn, mx;
		assign o  = s_tdata[a*CW +: CW];
		assign d  = s_tdata[(a+3)*CW +: CW];
		assign mn = box_q[a];
		assign mx = box_q[a+3];
		always_ff @(posedge clk) begin
			if (en) begin
				dmn_s1[a] <= (CW+1)'({mn[CW-1], mn} - {o[CW-1], o});
				dmx_s1[a] <= (CW+1)'({mx[CW-1], mx} - {o[CW-1], o});
				dir_s1[a] <= (d == '0) ? CW'(1) : d;
				par_s1[a] <= (d == '0);
				pm_s1[a]  <= (o < mn) || (o > mx);
			end
		end
	end

	logic [CW-1:0] qa [NUM_AXES];
	logic [CW-1:0] qb [NUM_AXES];
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_div
		rbsi_div #(.CW(CW), .FB(FRAC_BITS)) u_da (
			.clk(clk), .arst_n(arst_n), .en(en),
			.num(dmn_s1[a]), .den(dir_s1[a]), .quo(qa[a]));
		rbsi_div #(.CW(CW), .FB(FRAC_BITS)) u_db (
			.clk(clk), .arst_n(arst_n), .en(en),
			.num(dmx_s1[a]), .den(dir_s1[a]), .quo(qb[a]));
	end

	// Delay parallel flags alongside the divider
	logic [2*NUM_AXES-1:0] pf_d [DL];
	always_ff @(posedge clk) begin
		if (en) begin
			pf_d[0] <= {par_s1[2], par_s1[1], par_s1[0], pm_s1[2], pm_s1[1], pm_s1[0]};
			for (int i = 1; i < DL; i++) pf_d[i] <= pf_d[i-1];
		end
	end

	// Stage 2: order each slab interval
	logic signed [CW-1:0] lo_s2 [NUM_AXES];
	logic signed [CW-1:0] hi_s2 [NUM_AXES];
	logic                 miss_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				if (pf_d[DL-1][NUM_AXES+a]) begin
					lo_s2[a] <= TMIN;
					hi_s2[a] <= TMAX;
				end else if ($signed(qa[a]) > $signed(qb[a])) begin
					lo_s2[a] <= qb[a];
					hi_s2[a] <= qa[a];
				end else begin
					lo_s2[a] <= qa[a];
					hi_s2[a] <= qb[a];
				end
			end
			miss_s2 <= |(pf_d[DL-1][NUM_AXES-1:0] & pf_d[DL-1][2*NUM_AXES-1:NUM_AXES]);
		end
	end

	// Stage 3: intersect intervals
	logic signed [CW-1:0] tn, tf;
	always_comb begin
		tn = lo_s2[0];
		tf = hi_s2[0];
		if (lo_s2[1] > tn) tn = lo_s2[1];
		if (lo_s2[2] > tn) tn = lo_s2[2];
		if (hi_s2[1] < tf) tf = hi_s2[1];
		if (hi_s2[2] < tf) tf = hi_s2[2];
	end

	logic          hit_s3;
	logic [CW-1:0] tn_s3, tf_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s3 <= !miss_s2 && !(tn > tf);
			tn_s3  <= (!miss_s2 && !(tn > tf)) ? tn : '0;
			tf_s3  <= (!miss_s2 && !(tn > tf)) ? tf : '0;
		end
	end
	assign m_tdata = {tf_s3, tn_s3};
	assign m_tuser = hit_s3;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("miss with nonzero distances");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> $signed(tn_s3) <= $signed(tf_s3))
		else $error("hit with empty interval");
endmodule

@@ dv/tb_ray_box_slab_intersect_top.sv @@
`timescale 1ns / 1ps

module tb_ray_box_slab_intersect_top import rbsi_pkg::*; ();

	localparam int CW = 32;
	localparam int FB = 16;
	localparam longint T_MAX = 64'sd2147483647;
	localparam longint T_MIN = -64'sd2147483648;
	localparam int LATENCY = CW + FB + 6;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [CW-1:0] dir_z;
		logic [CW-1:0] dir_y;
		logic [CW-1:0] dir_x;
		logic [CW-1:0] origin_z;
		logic [CW-1:0] origin_y;
		logic [CW-1:0] origin_x;
	} ray_t;

	typedef struct packed {
		logic          hit;
		logic [CW-1:0] t_near;
		logic [CW-1:0] t_far;
	} hit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [6*CW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [2*CW-1:0] m_tdata;
	logic m_tuser;

	ray_box_slab_intersect_top dut (.*);

	always #5 clk = ~clk;

	logic [CW-1:0] box_lo [NUM_AXES];
	logic [CW-1:0] box_hi [NUM_AXES];

	ray_t ray_queue[$];
	hit_t hit_queue[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	longint cycles = 0;

	// (num << FB) / den, truncated toward zero, saturated; den != 0
	function automatic longint slab_div(longint num, longint den);
		logic neg;
		longint unsigned n, d, lim, q, r;
		neg = (num < 0) != (den < 0);
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		lim = neg ? 64'd2147483648 : 64'd2147483647;
		q = n / d;
		r = n % d;
		if (q > lim)
			return neg ? T_MIN : T_MAX;
		for (int i = 0; i < FB; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 1;
			end
			if (q > lim)
				return neg ? T_MIN : T_MAX;
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic hit_t predict_hit(ray_t ray);
		hit_t res;
		longint o[3], d[3], mn, mx, a, b, tn, tf;
		logic ok;
		o = '{longint'(signed'(ray.origin_x)), longint'(signed'(ray.origin_y)),
			longint'(signed'(ray.origin_z))};
		d = '{longint'(signed'(ray.dir_x)), longint'(signed'(ray.dir_y)),
			longint'(signed'(ray.dir_z))};
		ok = 1'b1;
		tn = T_MIN;
		tf = T_MAX;
		for (int k = 0; k < 3; k++) begin
			mn = longint'(signed'(box_lo[k]));
			mx = longint'(signed'(box_hi[k]));
			if (d[k] == 0) begin
				if (o[k] < mn || o[k] > mx)
					ok = 1'b0;
			end else begin
				a = slab_div(mn - o[k], d[k]);
				b = slab_div(mx - o[k], d[k]);
				if (a > b) begin
					longint t;
					t = a; a = b; b = t;
				end
				if (a > tn) tn = a;
				if (b < tf) tf = b;
			end
		end
		if (tn > tf)
			ok = 1'b0;
		res.hit = ok;
		res.t_near = ok ? tn[CW-1:0] : '0;
		res.t_far = ok ? tf[CW-1:0] : '0;
		return res;
	endfunction

	// driver; the item on the bus stays at the queue front until its transfer
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (s_tvalid)
					void'(ray_queue.pop_front());
				if (ray_queue.size() > 0 &&
						$urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= ray_queue[0];
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	// predict on the accepting edge, before the driver pops it
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && s_tvalid && s_tready)
			hit_queue.push_back(predict_hit(ray_t'(s_tdata)));
	end

	// monitor
	always @(posedge clk) begin
		hit_t exp_hit;
		if (arst_n && m_tvalid && m_tready) begin
			if (hit_queue.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
			end else begin
				exp_hit = hit_queue.pop_front();
				if (m_tuser !== exp_hit.hit) begin
					$error("hit exp %0d got %0d", exp_hit.hit, m_tuser);
					errors++;
				end
				if (m_tdata[CW-1:0] !== exp_hit.t_near) begin
					$error("t_near exp %h got %h", exp_hit.t_near, m_tdata[CW-1:0]);
					errors++;
				end
				if (m_tdata[2*CW-1:CW] !== exp_hit.t_far) begin
					$error("t_far exp %h got %h", exp_hit.t_far, m_tdata[2*CW-1:CW]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("ray_box_slab_intersect_top verification failed");
			$finish;
		end
	end

	task automatic write_reg(int unsigned idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= 5'(idx * 4); pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx < REG_MAX_X) box_lo[idx] = val;
		else box_hi[idx - REG_MAX_X] = val;
	endtask

	task automatic set_box(logic [CW-1:0] lx, ly, lz, hx, hy, hz);
		write_reg(REG_MIN_X, lx); write_reg(REG_MIN_Y, ly); write_reg(REG_MIN_Z, lz);
		write_reg(REG_MAX_X, hx); write_reg(REG_MAX_Y, hy); write_reg(REG_MAX_Z, hz);
	endtask

	task automatic drain;
		while (ray_queue.size() != 0 || hit_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [CW-1:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return CW'(signed'($urandom_range(20 << FB)) - (10 << FB));
			2: return CW'(signed'($urandom_range(4 << FB)) - (2 << FB));
			default: return '0;
		endcase
	endfunction

	function automatic ray_t rand_ray();
		ray_t r;
		int m;
		m = $urandom_range(9);
		r.origin_x = rand_coord(m < 8 ? 1 : 0);
		r.origin_y = rand_coord(m < 8 ? 1 : 0);
		r.origin_z = rand_coord(m < 8 ? 1 : 0);
		r.dir_x = $urandom_range(5) == 0 ? '0 : rand_coord(m < 7 ? 2 : 0);
		r.dir_y = $urandom_range(5) == 0 ? '0 : rand_coord(m < 7 ? 2 : 0);
		r.dir_z = $urandom_range(5) == 0 ? '0 : rand_coord(m < 7 ? 2 : 0);
		// aim some rays at the box center so hits are common
		if (m < 4) begin
			r.dir_x = CW'((longint'(signed'(box_lo[0])) + longint'(signed'(box_hi[0]))) / 2
				- longint'(signed'(r.origin_x))) >>> 2;
			r.dir_y = CW'((longint'(signed'(box_lo[1])) + longint'(signed'(box_hi[1]))) / 2
				- longint'(signed'(r.origin_y))) >>> 2;
			r.dir_z = CW'((longint'(signed'(box_lo[2])) + longint'(signed'(box_hi[2]))) / 2
				- longint'(signed'(r.origin_z))) >>> 2;
		end
		return r;
	endfunction

	initial begin
		ray_t r;
		for (int k = 0; k < 3; k++) begin
			box_lo[k] = '0;
			box_hi[k] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: unit box
		set_box(-(1 << FB), -(1 << FB), -(1 << FB), 1 << FB, 1 << FB, 1 << FB);
		r = '{dir_z: 0, dir_y: 0, dir_x: 1 << FB, origin_z: 0, origin_y: 0,
			origin_x: -(5 << FB)};
		ray_queue.push_back(r);                        // axis hit, two parallel slabs
		r.origin_y = 2 << FB;
		ray_queue.push_back(r);                        // parallel miss
		r.origin_y = 1 << FB;
		ray_queue.push_back(r);                        // parallel on the face
		r = '{dir_z: 1 << FB, dir_y: 1 << FB, dir_x: 1 << FB, origin_z: -(1 << FB),
			origin_y: 1 << FB, origin_x: -(3 << FB)};
		ray_queue.push_back(r);                        // no common point, empty interval
		r = '{default: 0};
		ray_queue.push_back(r);                        // all parallel, inside
		r = '{dir_z: 1, dir_y: 1, dir_x: 1, origin_z: 0, origin_y: 0, origin_x: 0};
		ray_queue.push_back(r);                        // saturating quotients
		r = '{dir_z: 32'h80000000, dir_y: 32'h7fffffff, dir_x: 32'h80000000,
			origin_z: 32'h7fffffff, origin_y: 32'h80000000, origin_x: 32'h7fffffff};
		ray_queue.push_back(r);
		r = '{dir_z: 32'hffffffff, dir_y: 32'hffffffff, dir_x: 32'hffffffff,
			origin_z: 32'h80000000, origin_y: 32'h7fffffff, origin_x: 0};
		ray_queue.push_back(r);
		r = '{dir_z: -(1 << FB), dir_y: 3 << FB, dir_x: 1 << (FB - 1),
			origin_z: 4 << FB, origin_y: -(4 << FB), origin_x: -(4 << FB)};
		ray_queue.push_back(r);                        // empty combined interval
		drain();

		// extremes of the box, inverted box
		set_box(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		for (int i = 0; i < 8; i++) ray_queue.push_back(rand_ray());
		r = '{dir_z: 0, dir_y: 0, dir_x: 1, origin_z: 32'h80000000,
			origin_y: 32'h7fffffff, origin_x: 0};
		ray_queue.push_back(r);
		drain();
		set_box(5 << FB, 5 << FB, 5 << FB, -(5 << FB), -(5 << FB), -(5 << FB));
		ray_queue.push_back('{default: 0});           // zero dir with inverted box
		r = '{dir_z: 1 << FB, dir_y: 1 << FB, dir_x: 1 << FB, origin_z: 0,
			origin_y: 0, origin_x: 0};
		ray_queue.push_back(r);
		drain();

		// random phases
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			if (ph == 7)
				set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			else begin
				logic [CW-1:0] lo[3], hi[3];
				for (int k = 0; k < 3; k++) begin
					lo[k] = rand_coord(1);
					hi[k] = CW'(longint'(signed'(lo[k])) + $urandom_range(8 << FB));
				end
				set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
			end
			for (int i = 0; i < 140; i++) ray_queue.push_back(rand_ray());
			// fixed stretch without gaps inside each phase
			if (ph % 4 != 0) begin
				int keep_s, keep_r;
				keep_s = send_idle_pct; keep_r = recv_stall_pct;
				while (ray_queue.size() > 70) @(posedge clk);
				send_idle_pct = 0; recv_stall_pct = 0;
				while (ray_queue.size() > 40) @(posedge clk);
				send_idle_pct = keep_s; recv_stall_pct = keep_r;
			end
			drain();
		end

		if (errors == 0)
			$display("ray_box_slab_intersect_top verification clean");
		else
			$display("ray_box_slab_intersect_top verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
src/rbsi_pkg.sv
src/rbsi_div.sv
src/ray_box_slab_intersect_top.sv
dv/tb_ray_box_slab_intersect_top.sv
